[hw/rtl/small_matrix_inverse_real_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the small matrix inverse core
// Shared property forms, clocked on clock and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef SMALL_MATRIX_INVERSE_REAL_CORE_ASSERT_SVH
`define SMALL_MATRIX_INVERSE_REAL_CORE_ASSERT_SVH

// Same-cycle implication.
`define SMI_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SMI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/smi_pkg.sv]
// ---------------------------------------------------------------------------
// smi_pkg
// Types and constants shared by the small matrix inverse pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package smi_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int ORDER_WIDTH = 3;
   localparam int NELEM       = 9;
   localparam int QBITS       = 2 * FRAC_BITS;
   localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
   localparam int COF_WIDTH   = PROD_WIDTH + 1;
   localparam int HI_WIDTH    = COF_WIDTH - DATA_WIDTH;
   localparam int DET_WIDTH   = 3 * DATA_WIDTH + 2;
   localparam int LIM_WIDTH   = ((QBITS > DATA_WIDTH) ? QBITS : DATA_WIDTH) + 1;

   typedef logic signed [DATA_WIDTH-1:0] elem_type;
   typedef logic [COF_WIDTH-1:0]         cof_type;
   typedef logic [DET_WIDTH-1:0]         det_type;
   typedef logic [ORDER_WIDTH-1:0]       order_type;
   typedef logic [1:0]                   status_type;

   localparam status_type STATUS_OK          = 2'd0;
   localparam status_type STATUS_SINGULAR    = 2'd1;
   localparam status_type STATUS_UNSUPPORTED = 2'd2;
   localparam status_type STATUS_SATURATED   = 2'd3;

   localparam order_type ORDER_ZERO  = 3'd0;
   localparam order_type ORDER_ONE   = 3'd1;
   localparam order_type ORDER_TWO   = 3'd2;
   localparam order_type ORDER_THREE = 3'd3;

   typedef struct packed {
      order_type order;
      elem_type  in_00;
      elem_type  in_01;
      elem_type  in_02;
      elem_type  in_10;
      elem_type  in_11;
      elem_type  in_12;
      elem_type  in_20;
      elem_type  in_21;
      elem_type  in_22;
   } req_type;

   typedef struct packed {
      status_type status;
      elem_type   inv_00;
      elem_type   inv_01;
      elem_type   inv_02;
      elem_type   inv_10;
      elem_type   inv_11;
      elem_type   inv_12;
      elem_type   inv_20;
      elem_type   inv_21;
      elem_type   inv_22;
   } rsp_type;

   // Numerators, the small-order determinant and the first column of the
   // cofactor matrix with the top row, for the 3x3 determinant.
   typedef struct packed {
      order_type                order;
      cof_type [NELEM-1:0]      num;
      cof_type                  det_small;
      elem_type [2:0]           top;
      cof_type [2:0]            col;
   } cof_out_type;

   typedef struct packed {
      status_type base;
      logic       clear;
   } tag_type;

   typedef struct packed {
      det_type          rem;
      logic [QBITS-1:0] quo;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      tag_type               tag;
      det_type               dmag;
      lane_type [NELEM-1:0]  lane;
   } div_type;

   function automatic cof_type elem_to_cof(elem_type x);
      return {{(COF_WIDTH-DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
   endfunction

   function automatic det_type cof_to_det(cof_type x);
      return {{(DET_WIDTH-COF_WIDTH){x[COF_WIDTH-1]}}, x};
   endfunction

endpackage

`default_nettype wire

[hw/rtl/smi_cofactor.sv]
// ---------------------------------------------------------------------------
// smi_cofactor
// Two stages: element products, then cofactors and per-order numerators.
// ---------------------------------------------------------------------------
`default_nettype none

module smi_cofactor (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire smi_pkg::req_type     in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output smi_pkg::cof_out_type      out_data
);
   import smi_pkg::*;

   elem_type e [3][3];
   logic signed [PROD_WIDTH-1:0] p1_in [3][3];
   logic signed [PROD_WIDTH-1:0] p2_in [3][3];
   logic signed [PROD_WIDTH-1:0] p1_ff [3][3];
   logic signed [PROD_WIDTH-1:0] p2_ff [3][3];
   elem_type    e_ff [3][3];
   order_type   order_ff;
   cof_type     cof [3][3];
   cof_out_type out_in;
   cof_out_type out_ff;
   logic        v1_ff;
   logic        v2_ff;
   logic        adv1;
   logic        adv2;

   assign e[0][0] = in_data.in_00;
   assign e[0][1] = in_data.in_01;
   assign e[0][2] = in_data.in_02;
   assign e[1][0] = in_data.in_10;
   assign e[1][1] = in_data.in_11;
   assign e[1][2] = in_data.in_12;
   assign e[2][0] = in_data.in_20;
   assign e[2][1] = in_data.in_21;
   assign e[2][2] = in_data.in_22;

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         assign p1_in[i][j] = e[(j+1)%3][(i+1)%3] * e[(j+2)%3][(i+2)%3];
         assign p2_in[i][j] = e[(j+1)%3][(i+2)%3] * e[(j+2)%3][(i+1)%3];
         assign cof[i][j] = {p1_ff[i][j][PROD_WIDTH-1], p1_ff[i][j]}
                          - {p2_ff[i][j][PROD_WIDTH-1], p2_ff[i][j]};
      end
   end

   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      out_in       = '0;
      out_in.order = order_ff;
      for (int k = 0; k < 3; k++) begin
         out_in.top[k] = e_ff[0][k];
         out_in.col[k] = cof[k][0];
      end
      case (order_ff)
         ORDER_ONE: begin
            out_in.num[0]    = COF_WIDTH'(1);
            out_in.det_small = elem_to_cof(e_ff[0][0]);
         end
         ORDER_TWO: begin
            out_in.num[0]    = elem_to_cof(e_ff[1][1]);
            out_in.num[1]    = -elem_to_cof(e_ff[0][1]);
            out_in.num[3]    = -elem_to_cof(e_ff[1][0]);
            out_in.num[4]    = elem_to_cof(e_ff[0][0]);
            out_in.det_small = cof[2][2];
         end
         ORDER_THREE: begin
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  out_in.num[3*i+j] = cof[i][j];
               end
            end
            out_in.det_small = cof[2][2];
         end
         default: begin
            // No inverse is formed; a nonzero divisor keeps the divider quiet.
            out_in.det_small = COF_WIDTH'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         e_ff     <= e;
         order_ff <= in_data.order;
      end
      if (adv2) out_ff <= out_in;
   end

   assign out_valid = v2_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

[hw/rtl/smi_determinant.sv]
// ---------------------------------------------------------------------------
// smi_determinant
// Five stages: split determinant products, partial sums, determinant,
// magnitudes and signs, then the overflow test that seeds the divider.
// ---------------------------------------------------------------------------
`default_nettype none

module smi_determinant (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire smi_pkg::cof_out_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output smi_pkg::div_type          out_data
);
   import smi_pkg::*;

   localparam int NSTAGE = 5;

   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE-1:0] adv;

   // Stage 1
   order_type           order1_ff;
   cof_type [NELEM-1:0] num1_ff;
   cof_type             dsm1_ff;
   logic signed [COF_WIDTH-1:0] lo_in [3];
   logic signed [COF_WIDTH-1:0] hi_in [3];
   logic signed [COF_WIDTH-1:0] lo_ff [3];
   logic signed [COF_WIDTH-1:0] hi_ff [3];
   // Stage 2
   order_type           order2_ff;
   cof_type [NELEM-1:0] num2_ff;
   cof_type             dsm2_ff;
   det_type             t_in [3];
   det_type             t_ff [3];
   // Stage 3
   order_type           order3_ff;
   cof_type [NELEM-1:0] num3_ff;
   det_type             det_in;
   det_type             det_ff;
   // Stage 4
   tag_type             tag_in;
   tag_type             tag4_ff;
   det_type             dmag4_ff;
   logic                dneg;
   cof_type             nmag_in [NELEM];
   cof_type             nmag4_ff [NELEM];
   logic [NELEM-1:0]    nneg4_ff;
   logic                dneg4_ff;
   // Stage 5
   div_type             div_in;
   div_type             div_ff;

   for (genvar k = 0; k < 3; k++) begin : g_part
      assign lo_in[k] = in_data.top[k]
                      * $signed({1'b0, in_data.col[k][DATA_WIDTH-1:0]});
      assign hi_in[k] = in_data.top[k]
                      * $signed(in_data.col[k][COF_WIDTH-1:DATA_WIDTH]);
      assign t_in[k]  = (cof_to_det(hi_ff[k]) << DATA_WIDTH) + cof_to_det(lo_ff[k]);
   end

   for (genvar k = 0; k < NSTAGE; k++) begin : g_adv
      if (k == NSTAGE - 1) begin : g_last
         assign adv[k] = !v_ff[k] || out_ready;
      end else begin : g_mid
         assign adv[k] = !v_ff[k] || adv[k+1];
      end
   end
   assign in_ready  = adv[0];
   assign out_valid = v_ff[NSTAGE-1];
   assign out_data  = div_ff;

   assign det_in = (order2_ff == ORDER_THREE) ? (t_ff[0] + t_ff[1] + t_ff[2])
                                              : cof_to_det(dsm2_ff);
   assign dneg   = det_ff[DET_WIDTH-1];

   always_comb begin
      for (int l = 0; l < NELEM; l++) begin
         nmag_in[l] = num3_ff[l][COF_WIDTH-1] ? -num3_ff[l] : num3_ff[l];
      end
      tag_in = '{base: STATUS_OK, clear: 1'b0};
      if (order3_ff > ORDER_THREE) begin
         tag_in = '{base: STATUS_UNSUPPORTED, clear: 1'b1};
      end else if (order3_ff == ORDER_ZERO) begin
         tag_in = '{base: STATUS_OK, clear: 1'b1};
      end else if (det_ff == '0) begin
         tag_in = '{base: STATUS_SINGULAR, clear: 1'b1};
      end
   end

   always_comb begin
      div_in      = '0;
      div_in.tag  = tag4_ff;
      div_in.dmag = dmag4_ff;
      for (int l = 0; l < NELEM; l++) begin
         div_in.lane[l].rem = DET_WIDTH'(nmag4_ff[l]);
         div_in.lane[l].neg = nneg4_ff[l] ^ dneg4_ff;
         // A numerator not below the divisor puts the quotient past every limit.
         div_in.lane[l].ovf = DET_WIDTH'(nmag4_ff[l]) >= dmag4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         order1_ff <= in_data.order;
         num1_ff   <= in_data.num;
         dsm1_ff   <= in_data.det_small;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
      end
      if (adv[1]) begin
         order2_ff <= order1_ff;
         num2_ff   <= num1_ff;
         dsm2_ff   <= dsm1_ff;
         t_ff      <= t_in;
      end
      if (adv[2]) begin
         order3_ff <= order2_ff;
         num3_ff   <= num2_ff;
         det_ff    <= det_in;
      end
      if (adv[3]) begin
         tag4_ff  <= tag_in;
         dneg4_ff <= dneg;
         dmag4_ff <= dneg ? -det_ff : det_ff;
         nmag4_ff <= nmag_in;
         for (int l = 0; l < NELEM; l++) begin
            nneg4_ff[l] <= num3_ff[l][COF_WIDTH-1];
         end
      end
      if (adv[4]) div_ff <= div_in;
   end

endmodule

`default_nettype wire

[hw/rtl/smi_divider.sv]
// ---------------------------------------------------------------------------
// smi_divider
// Restoring division, one quotient bit per stage on all nine lanes at once.
// ---------------------------------------------------------------------------
`default_nettype none

module smi_divider (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire smi_pkg::div_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output smi_pkg::div_type      out_data
);
   import smi_pkg::*;

   div_type          src [QBITS];
   div_type          nxt [QBITS];
   div_type          stage_ff [QBITS];
   logic [QBITS-1:0] vsrc;
   logic [QBITS-1:0] v_ff;
   logic [QBITS-1:0] adv;

   for (genvar k = 0; k < QBITS; k++) begin : g_step
      logic [DET_WIDTH:0] r2 [NELEM];
      logic [DET_WIDTH:0] diff [NELEM];

      if (k == 0) begin : g_first
         assign src[k]  = in_data;
         assign vsrc[k] = in_valid;
      end else begin : g_next
         assign src[k]  = stage_ff[k-1];
         assign vsrc[k] = v_ff[k-1];
      end

      if (k == QBITS - 1) begin : g_last
         assign adv[k] = !v_ff[k] || out_ready;
      end else begin : g_mid
         assign adv[k] = !v_ff[k] || adv[k+1];
      end

      always_comb begin
         nxt[k] = src[k];
         for (int l = 0; l < NELEM; l++) begin
            r2[l]   = {src[k].lane[l].rem, 1'b0};
            diff[l] = r2[l] - {1'b0, src[k].dmag};
            if (r2[l] >= {1'b0, src[k].dmag}) begin
               nxt[k].lane[l].rem = diff[l][DET_WIDTH-1:0];
               nxt[k].lane[l].quo = {src[k].lane[l].quo[QBITS-2:0], 1'b1};
            end else begin
               nxt[k].lane[l].rem = r2[l][DET_WIDTH-1:0];
               nxt[k].lane[l].quo = {src[k].lane[l].quo[QBITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) stage_ff[k] <= nxt[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < QBITS; k++) begin
            if (adv[k]) v_ff[k] <= vsrc[k];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[QBITS-1];
   assign out_data  = stage_ff[QBITS-1];

endmodule

`default_nettype wire

[hw/rtl/small_matrix_inverse_real_core.sv]
// Path from an accepted request to its response: 2 cofactor stages,
// 5 determinant stages, 32 divider stages, 1 output register.
// Throughput: one matrix per cycle while responses are taken; every stage has
// its own valid bit and a stalled response holds only the stages behind it that are full.
// Reset clears all valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
// small_matrix_inverse_real_core
// Closed-form inverse of a real matrix of order 0 to 3 in signed Q16.16.
// ---------------------------------------------------------------------------
`default_nettype none

module small_matrix_inverse_real_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire smi_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output smi_pkg::rsp_type      rsp_data
);
   import smi_pkg::*;
   `include "small_matrix_inverse_real_core_assert.svh"

   logic        cof_valid;
   logic        cof_ready;
   cof_out_type cof_data;
   logic        det_valid;
   logic        det_ready;
   div_type     det_data;
   logic        div_valid;
   logic        div_ready;
   div_type     div_data;

   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;
   logic [LIM_WIDTH-1:0] qx [NELEM];
   logic [LIM_WIDTH-1:0] lim [NELEM];
   logic [LIM_WIDTH-1:0] mag [NELEM];
   logic [LIM_WIDTH-1:0] sval [NELEM];
   logic [NELEM-1:0]     sat;
   elem_type             res [NELEM];

   smi_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .out_data  (cof_data)
   );

   smi_determinant u_determinant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .in_data   (cof_data),
      .out_valid (det_valid),
      .out_ready (det_ready),
      .out_data  (det_data)
   );

   smi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (det_valid),
      .in_ready  (det_ready),
      .in_data   (det_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   assign div_ready = !rsp_valid_ff || rsp_ready;

   // Saturate each quotient to the signed range, then apply the sign.
   always_comb begin
      for (int l = 0; l < NELEM; l++) begin
         qx[l]   = LIM_WIDTH'(div_data.lane[l].quo);
         lim[l]  = (LIM_WIDTH'(1) << (DATA_WIDTH - 1))
                 - LIM_WIDTH'(!div_data.lane[l].neg);
         sat[l]  = div_data.lane[l].ovf || (qx[l] > lim[l]);
         mag[l]  = sat[l] ? lim[l] : qx[l];
         sval[l] = div_data.lane[l].neg ? -mag[l] : mag[l];
         res[l]  = div_data.tag.clear ? '0 : sval[l][DATA_WIDTH-1:0];
      end
      rsp_data_in.inv_00 = res[0];
      rsp_data_in.inv_01 = res[1];
      rsp_data_in.inv_02 = res[2];
      rsp_data_in.inv_10 = res[3];
      rsp_data_in.inv_11 = res[4];
      rsp_data_in.inv_12 = res[5];
      rsp_data_in.inv_20 = res[6];
      rsp_data_in.inv_21 = res[7];
      rsp_data_in.inv_22 = res[8];
      if (div_data.tag.clear) begin
         rsp_data_in.status = div_data.tag.base;
      end else if (|sat) begin
         rsp_data_in.status = STATUS_SATURATED;
      end else begin
         rsp_data_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SMI_ASSERT(a_error_clears_result,
      rsp_valid_ff && (rsp_data_ff.status == STATUS_SINGULAR ||
                       rsp_data_ff.status == STATUS_UNSUPPORTED),
      rsp_data_ff.inv_00 == '0 && rsp_data_ff.inv_11 == '0 && rsp_data_ff.inv_22 == '0,
      "error status with a nonzero inverse element")
   `SMI_ASSERT(a_stall_only_when_blocked, !req_ready, rsp_valid_ff && !rsp_ready,
      "request stalled while the response side can move")
   `SMI_ASSERT_NEXT(a_divider_holds, div_valid && !div_ready,
      div_valid && $stable(div_data), "divider output changed while stalled")

endmodule

`default_nettype wire
